>>> design/derivative_outlier_suppressor_core_defines.svh
// Assertion macros for the derivative outlier suppressor.
`ifndef DERIVATIVE_OUTLIER_SUPPRESSOR_CORE_DEFINES_SVH
`define DERIVATIVE_OUTLIER_SUPPRESSOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on the rising clock, off while in reset.
`define DOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold.
`define DOS_ASSERT_NEVER(lbl, expr, msg) \
  `DOS_ASSERT(lbl, !(expr), msg)

`else

`define DOS_ASSERT(lbl, prop, msg)
`define DOS_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> design/dos_pkg.sv
// Types and constants shared by the derivative outlier suppressor.
`default_nettype none

package dos_pkg;

  localparam int POS_OUT_W   = 20;
  localparam int VALUE_W     = 32;
  localparam int LIMIT_W     = 31;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Write-back queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LEVEL     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ABS        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DERIVATIVE = 2'd3;

  // Saturation bounds for clamped values, on the 34-bit working width
  localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_LO = 34'sh3_8000_0000;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

  // One write-back transaction
  typedef struct packed {
    logic [POS_OUT_W-1:0]      position;
    logic signed [VALUE_W-1:0] value;
    logic                      is_nan;
    logic                      last;
    logic                      done;
  } res_t;

  // |v - zl| > ma, exact
  function automatic logic out_of_range(input logic signed [VALUE_W-1:0] v,
                                        input logic signed [VALUE_W-1:0] zl,
                                        input logic [LIMIT_W-1:0] ma);
    logic signed [32:0] d;
    logic [32:0]        mag;
    d   = 33'(v) - 33'(zl);
    mag = d[32] ? 33'(-d) : 33'(d);
    return mag > {2'b00, ma};
  endfunction

  // |d| > lim
  function automatic logic abs_gt(input logic signed [34:0] d,
                                  input logic [VALUE_W-1:0] lim);
    logic [34:0] mag;
    mag = d[34] ? 35'(-d) : 35'(d);
    return mag > {3'b000, lim};
  endfunction

  function automatic res_t make_res(input logic [POS_OUT_W-1:0] pos,
                                    input logic signed [VALUE_W-1:0] val,
                                    input logic bad);
    res_t r;
    r.position = pos;
    r.value    = bad ? '0 : val;
    r.is_nan   = bad;
    r.last     = 1'b0;
    r.done     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/derivative_outlier_suppressor_core.sv
// Derivative outlier suppressor: top level with state, verdict logic and write-back queue.
`default_nettype none
`include "derivative_outlier_suppressor_core_defines.svh"

// Streams Q16.16 samples of a record, one transaction per sample, and emits
// write-back transactions (position, value, invalid flag). In clip mode each
// finite sample yields one write-back clamped to zero_level +/- max_abs, a
// NaN one an invalid write-back. In check mode a finite sample is held until
// the next finite one arrives, then judged against range and against the
// mean of its finite neighbors; the last finite sample of a record is judged
// against range and half its step from the previous one. A sample yields 0,
// 1 or 2 write-backs; out_last marks the last one of a sample, and
// out_record_done the last one of a record. Rate: one sample per cycle while
// in_stall is low. A sample is captured in an input register, its verdicts
// are formed combinationally and pushed into a 4-entry write-back queue,
// whose head is driven on the output. The queue drains one write-back per
// cycle while out_stall is low, so samples that yield two write-backs are
// limited by the output side. in_stall rises when the queue cannot take two
// more entries while a sample waits.
// Configuration writes are only allowed with the block idle.
module derivative_outlier_suppressor_core
  import dos_pkg::*;
#(
  parameter int POSITION_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // samples in
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [VALUE_W-1:0] in_sample_value,
  input  wire logic                   in_sample_is_nan,
  input  wire logic                   in_last_in_record,
  // write-backs out
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [POS_OUT_W-1:0]        out_position,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic                        out_is_nan,
  output logic                        out_last,
  output logic                        out_record_done
);

  // ---------------------------------------------------------------- config
  logic                      clip_mode_r;
  logic signed [VALUE_W-1:0] zero_level_r;
  logic [LIMIT_W-1:0]        max_abs_r;
  logic [LIMIT_W-1:0]        max_deriv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_mode_r  <= 1'b0;
      zero_level_r <= '0;
      max_abs_r    <= LIMIT_RESET;
      max_deriv_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIP_MODE:      clip_mode_r  <= cfg_data[0];
        REG_ZERO_LEVEL:     zero_level_r <= cfg_data;
        REG_MAX_ABS:        max_abs_r    <= cfg_data[LIMIT_W-1:0];
        REG_MAX_DERIVATIVE: max_deriv_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic                      s1_valid_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic                      s1_nan_r;
  logic                      s1_last_r;

  logic [FIFO_AW:0] fifo_cnt_r;
  logic             s1_advance;
  logic             in_accept;

  // Item leaves the input register only when the queue has room for two.
  assign s1_advance = s1_valid_r && (fifo_cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_value_r <= in_sample_value;
      s1_nan_r   <= in_sample_is_nan;
      s1_last_r  <= in_last_in_record;
    end
  end

  // ---------------------------------------------------------- record state
  logic [POSITION_BITS-1:0]  sample_cnt_r,  sample_cnt_nxt;
  logic                      held_valid_r,  held_valid_nxt;
  logic signed [VALUE_W-1:0] held_value_r,  held_value_nxt;
  logic [POSITION_BITS-1:0]  held_pos_r,    held_pos_nxt;
  logic signed [VALUE_W-1:0] prev_value_r,  prev_value_nxt;

  logic [POS_OUT_W-1:0] cnt_pos_out;
  logic [POS_OUT_W-1:0] held_pos_out;

  // Positions leave as their low POS_OUT_W bits
  generate
    if (POSITION_BITS >= POS_OUT_W) begin : g_pos_trunc
      assign cnt_pos_out  = sample_cnt_r[POS_OUT_W-1:0];
      assign held_pos_out = held_pos_r[POS_OUT_W-1:0];
    end else begin : g_pos_ext
      assign cnt_pos_out  = {{(POS_OUT_W-POSITION_BITS){1'b0}}, sample_cnt_r};
      assign held_pos_out = {{(POS_OUT_W-POSITION_BITS){1'b0}}, held_pos_r};
    end
  endgenerate

  // ------------------------------------------------------------- verdicts
  logic                      oor_held, oor_new;
  logic                      flush_bad, mid_bad, new_bad;
  logic signed [VALUE_W-1:0] prev_new;
  logic [VALUE_W-1:0]        deriv_lim;
  logic signed [33:0]        clip_hi, clip_lo, clip_r;
  logic signed [VALUE_W-1:0] clip_value;

  logic res_a_vld, res_b_vld;
  res_t res_a, res_b;
  res_t push_0, push_1;
  logic [1:0] push_n;

  always_comb begin
    deriv_lim = {max_deriv_r, 1'b0};
    oor_held  = out_of_range(held_value_r, zero_level_r, max_abs_r);
    oor_new   = out_of_range(s1_value_r, zero_level_r, max_abs_r);
    // final verdict on the held sample
    flush_bad = oor_held ||
                abs_gt(35'(held_value_r) - 35'(prev_value_r), deriv_lim);
    // held sample against the mean of its neighbors, doubled
    mid_bad   = oor_held ||
                abs_gt(35'(held_value_r) + 35'(held_value_r)
                       - 35'(prev_value_r) - 35'(s1_value_r), deriv_lim);
    // new sample flushed at record end
    prev_new  = held_valid_r ? held_value_r : s1_value_r;
    new_bad   = oor_new ||
                abs_gt(35'(s1_value_r) - 35'(prev_new), deriv_lim);

    // clamp, then saturate
    clip_hi = 34'(zero_level_r) + 34'(signed'({1'b0, max_abs_r}));
    clip_lo = 34'(zero_level_r) - 34'(signed'({1'b0, max_abs_r}));
    clip_r  = 34'(s1_value_r);
    if (clip_r > clip_hi) begin
      clip_r = clip_hi;
    end else if (clip_r < clip_lo) begin
      clip_r = clip_lo;
    end
    if (clip_r > SAT_HI) begin
      clip_r = SAT_HI;
    end
    if (clip_r < SAT_LO) begin
      clip_r = SAT_LO;
    end
    clip_value = clip_r[VALUE_W-1:0];

    // candidate write-backs: a precedes b
    res_a = make_res(held_pos_out, held_value_r, flush_bad);
    res_b = make_res(cnt_pos_out, '0, 1'b1);
    res_a_vld = 1'b0;
    res_b_vld = 1'b1;
    if (clip_mode_r) begin
      res_a_vld = held_valid_r;
      if (!s1_nan_r) begin
        res_b = make_res(cnt_pos_out, clip_value, 1'b0);
      end
    end else if (s1_nan_r) begin
      res_a_vld = s1_last_r && held_valid_r;
    end else begin
      res_a_vld = held_valid_r;
      res_a     = make_res(held_pos_out, held_value_r, mid_bad);
      res_b_vld = s1_last_r;
      res_b     = make_res(cnt_pos_out, s1_value_r, new_bad);
    end

    // pack into queue order, tag the final one
    push_0 = res_a_vld ? res_a : res_b;
    push_1 = res_b;
    push_n = {1'b0, res_a_vld} + {1'b0, res_b_vld};
    if (push_n == 2'd2) begin
      push_1.last = 1'b1;
      push_1.done = s1_last_r;
    end else begin
      push_0.last = 1'b1;
      push_0.done = s1_last_r;
    end

    // state update
    sample_cnt_nxt = sample_cnt_r + POSITION_BITS'(1);
    held_valid_nxt = held_valid_r;
    held_value_nxt = held_value_r;
    held_pos_nxt   = held_pos_r;
    prev_value_nxt = prev_value_r;
    if (s1_last_r) begin
      sample_cnt_nxt = '0;
      held_valid_nxt = 1'b0;
      held_value_nxt = '0;
      held_pos_nxt   = '0;
      prev_value_nxt = '0;
    end else if (clip_mode_r) begin
      held_valid_nxt = 1'b0;
    end else if (!s1_nan_r) begin
      prev_value_nxt = prev_new;
      held_value_nxt = s1_value_r;
      held_pos_nxt   = sample_cnt_r;
      held_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '0;
      held_valid_r <= 1'b0;
      held_value_r <= '0;
      held_pos_r   <= '0;
      prev_value_r <= '0;
    end else if (s1_advance) begin
      sample_cnt_r <= sample_cnt_nxt;
      held_valid_r <= held_valid_nxt;
      held_value_r <= held_value_nxt;
      held_pos_r   <= held_pos_nxt;
      prev_value_r <= prev_value_nxt;
    end
  end

  // ------------------------------------------------------- write-back queue
  res_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [1:0]       n_push;
  logic             pop;
  res_t             head;

  assign n_push = s1_advance ? push_n : 2'd0;
  assign pop    = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_mem[wr_ptr_r] <= push_0;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wr_ptr_r + FIFO_AW'(1)] <= push_1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + FIFO_AW'(n_push);
      rd_ptr_r   <= rd_ptr_r + FIFO_AW'(pop);
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
    end
  end

  assign head            = fifo_mem[rd_ptr_r];
  assign out_valid       = (fifo_cnt_r != '0);
  assign out_position    = head.position;
  assign out_value       = head.value;
  assign out_is_nan      = head.is_nan;
  assign out_last        = head.last;
  assign out_record_done = head.done;

  // ------------------------------------------------------------ assertions
  // queue never overfills
  `DOS_ASSERT_NEVER(a_fifo_overflow, fifo_cnt_r > (FIFO_AW+1)'(FIFO_DEPTH), "write-back queue overflow")
  // record end clears counter and held sample
  `DOS_ASSERT(a_record_end_clears, (s1_advance && s1_last_r) |=> (sample_cnt_r == '0 && !held_valid_r), "record end did not clear state")
  // nothing is held after a clip-mode sample
  `DOS_ASSERT(a_clip_no_hold, (s1_advance && clip_mode_r) |=> !held_valid_r, "sample held in clip mode")
  // record end always closes a sample's write-backs
  `DOS_ASSERT(a_done_is_last, (out_valid && out_record_done) |-> out_last, "record_done without out_last")

endmodule

`default_nettype wire
